[hdl/serc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serc_pkg - shared types and constants of the speed error rate corrector
// Register indexes, reset values, field widths and the controller states.
// ----------------------------------------------------------------------------
package serc_pkg;

    localparam int C_SPEED_W = 16;
    localparam int C_TIME_W  = 48;
    localparam int C_CFG_W   = 24;

    // |error difference| * 1e6 stays below 2**36
    localparam int C_NUM_W  = 36;
    localparam int C_DCNT_W = 6;
    localparam logic [19:0] C_US_PER_S = 20'd1000000;

    localparam logic [15:0] C_RST_GAIN     = 16'd1280;
    localparam logic [23:0] C_RST_MAX_AGE  = 24'd4100000;
    localparam logic [23:0] C_RST_PATIENCE = 24'd4000000;
    localparam logic [14:0] C_RST_RATE_THR = 15'd128;
    localparam logic [14:0] C_RST_ERR_THR  = 15'd256;
    localparam logic [15:0] C_RST_EQUIL    = 16'd5120;

    localparam logic [15:0] C_SAT_POS = 16'h7FFF;
    localparam logic [15:0] C_SAT_NEG = 16'h8000;

    typedef enum logic [2:0] {
        REG_GAIN     = 3'd0,
        REG_MAX_AGE  = 3'd1,
        REG_PATIENCE = 3'd2,
        REG_RATE_THR = 3'd3,
        REG_ERR_THR  = 3'd4,
        REG_EQUIL    = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

[hdl/speed_error_rate_corrector_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Each accepted item runs scan, multiply, a divide when an older sample is kept
// and the gap is positive (36 restoring steps, one quotient bit a cycle), then finish and emit.
// A new item is taken only in idle, after the last one is emitted; the
// history scan reads one entry a cycle.
// The output register lets the next item enter while a result waits.
// Reset (sync, active low) clears valid bits, ring pointer, last correction time.
// ----------------------------------------------------------------------------
// speed_error_rate_corrector_top - speed error rate and throttle correction
// Ages a ring of speed error samples, derives the error rate from the oldest
// kept sample with a bit-serial divider and issues a saturated amplitude.
// ----------------------------------------------------------------------------
module speed_error_rate_corrector_top
    import serc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // config write channel
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [23:0]  i_cfg_data,
    // sample stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [15:0] desired_speed, [31:16] measured_speed,
    // [79:32] sample_time, [127:80] current_time
    input  wire logic [127:0] s_axis_tdata,
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [15:0] amplitude, [16] boost_applied, [32:17] error_rate, [39:33] zero
    output logic [39:0]       m_axis_tdata
);

    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    t_state r_state, n_state;

    // configuration
    logic [15:0] r_gain;
    logic [23:0] r_max_age;
    logic [23:0] r_patience;
    logic [14:0] r_rate_thr;
    logic [14:0] r_err_thr;
    logic [15:0] r_equil;

    // history ring
    logic [C_TIME_W-1:0]  r_mem_time [HISTORY_DEPTH];
    logic [C_SPEED_W-1:0] r_mem_err  [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] r_hvalid;
    logic [IDX_W-1:0] r_wslot;
    logic [C_TIME_W-1:0] r_last_time;

    // scan
    logic [IDX_W-1:0] r_addr;
    logic [IDX_W-1:0] r_rd_idx;
    logic [CNT_W-1:0] r_cnt;
    logic             r_rd_vld;
    logic [C_TIME_W-1:0]  r_rd_time;
    logic [C_SPEED_W-1:0] r_rd_err;
    logic             r_found;

    // current item
    logic signed [C_SPEED_W-1:0] r_err;
    logic [C_TIME_W-1:0] r_tsamp;
    logic [C_TIME_W-1:0] r_now;
    logic [C_TIME_W-1:0] r_old_time;
    logic [C_SPEED_W-1:0] r_old_err;

    // rate
    logic                r_neg;
    logic                r_nonpos;
    logic [C_NUM_W-1:0]  r_num;
    logic [C_TIME_W-1:0] r_dt;
    logic [C_TIME_W-1:0] r_rem;
    logic [C_DCNT_W-1:0] r_dcnt;
    logic [15:0]         r_rate;
    logic signed [32:0]  r_prod;
    logic                r_issue;

    logic        r_m_valid;
    logic [39:0] r_m_data;

    // control
    logic w_accept;
    logic w_rd_en;
    logic w_wr_en;
    logic w_emit;
    logic w_cfg_we;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_cfg_we = i_cfg_valid && o_cfg_ready;

    // ------------------------------------------------------------------
    // datapath terms
    // ------------------------------------------------------------------
    logic signed [16:0] w_err_full;
    logic [15:0]        w_err_sat;
    always_comb begin
        w_err_full = 17'($signed(s_axis_tdata[15:0])) - 17'($signed(s_axis_tdata[31:16]));
        if (w_err_full[16] != w_err_full[15]) begin
            w_err_sat = w_err_full[16] ? C_SAT_NEG : C_SAT_POS;
        end else begin
            w_err_sat = w_err_full[15:0];
        end
    end

    // ageing of the entry read last cycle
    logic [C_TIME_W:0] w_age_diff;
    logic              w_aged;
    logic              w_kept;
    always_comb begin
        w_age_diff = {1'b0, r_now} - {1'b0, r_rd_time};
        w_aged = !w_age_diff[C_TIME_W] &&
                 (w_age_diff[C_TIME_W-1:0] >= {{(C_TIME_W-C_CFG_W){1'b0}}, r_max_age});
        w_kept = r_rd_vld && r_hvalid[r_rd_idx] && !w_aged;
    end

    logic [IDX_W-1:0] w_addr_inc;
    assign w_addr_inc = (r_addr == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : r_addr + IDX_W'(1);
    logic [IDX_W-1:0] w_wslot_inc;
    assign w_wslot_inc = (r_wslot == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : r_wslot + IDX_W'(1);

    // gap and difference magnitude
    logic [C_TIME_W:0]  w_dt_full;
    logic               w_nonpos;
    logic signed [16:0] w_diff;
    logic [15:0]        w_diff_mag;
    always_comb begin
        w_dt_full  = {1'b0, r_tsamp} - {1'b0, r_old_time};
        w_nonpos   = w_dt_full[C_TIME_W] || (w_dt_full[C_TIME_W-1:0] == '0);
        w_diff     = 17'(r_err) - 17'($signed(r_old_err));
        w_diff_mag = w_diff[16] ? 16'(-w_diff) : w_diff[15:0];
    end

    // restoring divide step
    logic [C_TIME_W:0]   w_shift;
    logic                w_ge;
    logic [C_TIME_W:0]   w_rem_next;
    always_comb begin
        w_shift    = {r_rem, r_num[C_NUM_W-1]};
        w_ge       = (w_shift >= {1'b0, r_dt});
        w_rem_next = w_ge ? (w_shift - {1'b0, r_dt}) : w_shift;
    end

    // rate from quotient
    logic [15:0] w_rate;
    always_comb begin
        if (!r_found) begin
            w_rate = '0;
        end else if (r_nonpos) begin
            w_rate = r_neg ? C_SAT_NEG : C_SAT_POS;
        end else if (!r_neg) begin
            w_rate = (r_num[C_NUM_W-1:15] != '0) ? C_SAT_POS : r_num[15:0];
        end else begin
            // magnitude 32768 maps exactly onto the negative limit
            if ((r_num[C_NUM_W-1:15] != '0) && (r_num[14:0] != '0 ||
                    r_num[C_NUM_W-1:16] != '0)) begin
                w_rate = C_SAT_NEG;
            end else begin
                w_rate = 16'(~r_num[15:0] + 16'd1);
            end
        end
    end

    logic [C_TIME_W:0] w_pat_diff;
    logic              w_issue;
    always_comb begin
        w_pat_diff = {1'b0, r_now} - {1'b0, r_last_time};
        w_issue = !w_pat_diff[C_TIME_W] &&
                  (w_pat_diff[C_TIME_W-1:0] >= {{(C_TIME_W-C_CFG_W){1'b0}}, r_patience});
    end

    // boost and amplitude
    logic [16:0]        w_abs_err;
    logic [16:0]        w_abs_rate;
    logic               w_boost;
    logic signed [33:0] w_round;
    logic signed [26:0] w_sum;
    logic [15:0]        w_amp;
    always_comb begin
        w_abs_err  = r_err[15] ? 17'(-17'(r_err)) : 17'(r_err);
        w_abs_rate = r_rate[15] ? 17'(-17'($signed(r_rate))) : {1'b0, r_rate};
        w_boost    = (w_abs_err > {2'b00, r_err_thr}) &&
                     ((w_abs_rate < {2'b00, r_rate_thr}) || (r_err[15] == r_rate[15]));
        // add half an LSB of Q8.8, then floor
        w_round    = 34'(r_prod) + 34'sd128;
        w_sum      = 27'($signed(r_equil));
        if (w_boost) begin
            w_sum = w_sum + 27'($signed(w_round[33:8]));
        end
        if (w_sum > 27'sd32767) begin
            w_amp = C_SAT_POS;
        end else if (w_sum < -27'sd32768) begin
            w_amp = C_SAT_NEG;
        end else begin
            w_amp = w_sum[15:0];
        end
    end

    // ------------------------------------------------------------------
    // controller
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_cnt == CNT_W'(HISTORY_DEPTH)) n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = (r_found && !w_nonpos) ? ST_DIV : ST_FIN;
            end
            ST_DIV: begin
                if (r_dcnt == C_DCNT_W'(C_NUM_W - 1)) n_state = ST_FIN;
            end
            ST_FIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_issue || !r_m_valid || m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_rd_en       = 1'b0;
        w_wr_en       = 1'b0;
        w_emit        = 1'b0;
        case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_SCAN: w_rd_en = (r_cnt != CNT_W'(HISTORY_DEPTH));
            ST_MUL:  w_wr_en = 1'b1;
            ST_EMIT: w_emit = r_issue && (!r_m_valid || m_axis_tready);
            default: ;
        endcase
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // ------------------------------------------------------------------
    // history memory
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_time <= r_mem_time[r_addr];
            r_rd_err  <= r_mem_err[r_addr];
        end
        if (w_wr_en) begin
            r_mem_time[r_wslot] <= r_tsamp;
            r_mem_err[r_wslot]  <= r_err;
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gain      <= C_RST_GAIN;
            r_max_age   <= C_RST_MAX_AGE;
            r_patience  <= C_RST_PATIENCE;
            r_rate_thr  <= C_RST_RATE_THR;
            r_err_thr   <= C_RST_ERR_THR;
            r_equil     <= C_RST_EQUIL;
            r_hvalid    <= '0;
            r_wslot     <= '0;
            r_last_time <= '0;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_dcnt      <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_rd_en;

            if (w_cfg_we) begin
                case (i_cfg_index)
                    REG_GAIN:     r_gain     <= i_cfg_data[15:0];
                    REG_MAX_AGE:  r_max_age  <= i_cfg_data;
                    REG_PATIENCE: r_patience <= i_cfg_data;
                    REG_RATE_THR: r_rate_thr <= i_cfg_data[14:0];
                    REG_ERR_THR:  r_err_thr  <= i_cfg_data[14:0];
                    REG_EQUIL:    r_equil    <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (w_accept) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
            end
            if (w_rd_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (r_rd_vld && w_aged) begin
                r_hvalid[r_rd_idx] <= 1'b0;
            end
            if (w_kept) begin
                r_found <= 1'b1;
            end

            if (w_wr_en) begin
                r_hvalid[r_wslot] <= 1'b1;
                r_wslot           <= w_wslot_inc;
                r_dcnt            <= '0;
            end
            if (r_state == ST_DIV) begin
                r_dcnt <= r_dcnt + C_DCNT_W'(1);
            end

            if (w_emit) begin
                r_m_valid   <= 1'b1;
                r_last_time <= r_now;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_err   <= w_err_sat;
            r_tsamp <= s_axis_tdata[79:32];
            r_now   <= s_axis_tdata[127:80];
            r_addr  <= r_wslot;
        end
        if (w_rd_en) begin
            r_rd_idx <= r_addr;
            r_addr   <= w_addr_inc;
        end
        // first kept entry in ring order is the oldest sample
        if (w_kept && !r_found) begin
            r_old_time <= r_rd_time;
            r_old_err  <= r_rd_err;
        end
        if (r_state == ST_MUL) begin
            r_neg    <= w_diff[16];
            r_nonpos <= w_nonpos;
            r_dt     <= w_dt_full[C_TIME_W-1:0];
            r_num    <= C_NUM_W'(w_diff_mag) * C_NUM_W'(C_US_PER_S);
            r_rem    <= '0;
        end
        if (r_state == ST_DIV) begin
            r_rem <= w_rem_next[C_TIME_W-1:0];
            r_num <= {r_num[C_NUM_W-2:0], w_ge};
        end
        if (r_state == ST_FIN) begin
            r_rate  <= w_rate;
            r_prod  <= 33'($signed({1'b0, r_gain})) * 33'(r_err);
            r_issue <= w_issue;
        end
        if (w_emit) begin
            r_m_data <= {7'd0, r_rate, w_boost, w_amp};
        end
    end

endmodule
`default_nettype wire

[tb/speed_error_rate_corrector_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speed_error_rate_corrector_top_test - self-checking bench for the corrector
// Streams speed samples into the block and keeps its own copy of the sample
// ring, the ageing, the rate divide and the patience timer. Every correction
// the block emits is compared field by field against that prediction. Runs
// reset defaults, field extremes, several random register settings, a stretch
// with no back-pressure, and time stamps at the top of the 48-bit range.
// ----------------------------------------------------------------------------
module speed_error_rate_corrector_top_test;
    import serc_pkg::*;

    localparam int DEPTH         = 16;
    localparam int SETTLE_CYCLES = DEPTH + 48;
    localparam longint US_PER_S  = 1000000;

    // indexes past the last register; writes there must be ignored
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [15:0] amplitude;
        logic        boost;
        logic [15:0] error_rate;
    } t_correction;

    logic           i_clk         = 1'b0;
    logic           i_rst_n       = 1'b0;
    logic           i_cfg_valid   = 1'b0;
    logic [2:0]     i_cfg_index   = '0;
    logic [23:0]    i_cfg_data    = '0;
    logic           s_axis_tvalid = 1'b0;
    logic [127:0]   s_axis_tdata  = '0;
    logic           m_axis_tready = 1'b0;
    logic           o_cfg_ready;
    logic           s_axis_tready;
    logic           m_axis_tvalid;
    logic [39:0]    m_axis_tdata;

    // predicted register file and sample ring
    logic [15:0]        reg_gain     = C_RST_GAIN;
    logic [23:0]        reg_max_age  = C_RST_MAX_AGE;
    logic [23:0]        reg_patience = C_RST_PATIENCE;
    logic [14:0]        reg_rate_thr = C_RST_RATE_THR;
    logic [14:0]        reg_err_thr  = C_RST_ERR_THR;
    logic signed [15:0] reg_equil    = C_RST_EQUIL;
    logic [47:0]        ring_stamp [DEPTH];
    int                 ring_error [DEPTH];
    bit                 ring_valid [DEPTH] = '{default: 1'b0};
    int unsigned        ring_wr      = 0;
    logic [47:0]        last_fix_us  = '0;

    t_correction expected_corrections [$];
    logic [47:0] track_now_us = '0;
    bit          no_gaps      = 1'b0;
    int          mismatch_count      = 0;
    int          items_sent          = 0;
    int          corrections_checked = 0;
    int          boosts_seen         = 0;
    int          reg_writes          = 0;

    speed_error_rate_corrector_top #(
        .HISTORY_DEPTH(DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic longint sat16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic void predict_correction(
        input  logic signed [15:0] desired,
        input  logic signed [15:0] measured,
        input  logic [47:0]        t_sample,
        input  logic [47:0]        t_now,
        output bit                 issued,
        output t_correction        fix
    );
        longint      err, diff, rate, amp, abs_err, abs_rate;
        int unsigned k;
        bit          found;
        err   = sat16(longint'(desired) - longint'(measured));
        rate  = 0;
        found = 1'b0;
        fix   = '0;

        // samples stamped in the future never age out
        for (int i = 0; i < DEPTH; i++)
            if (ring_valid[i] && t_now >= ring_stamp[i] &&
                t_now - ring_stamp[i] >= reg_max_age)
                ring_valid[i] = 1'b0;

        // oldest kept entry: first valid slot from the write pointer onward
        for (int i = 0; i < DEPTH; i++) begin
            k = (ring_wr + i) % DEPTH;
            if (!found && ring_valid[k]) begin
                found = 1'b1;
                diff  = err - ring_error[k];
                if (t_sample <= ring_stamp[k])
                    rate = (diff >= 0) ? 32767 : -32768;
                else
                    rate = sat16(diff * US_PER_S / longint'(t_sample - ring_stamp[k]));
            end
        end

        // a full ring loses its oldest entry, which sits at the write pointer
        ring_stamp[ring_wr] = t_sample;
        ring_error[ring_wr] = int'(err);
        ring_valid[ring_wr] = 1'b1;
        ring_wr = (ring_wr + 1) % DEPTH;

        issued = (t_now >= last_fix_us) && (t_now - last_fix_us >= reg_patience);
        if (!issued) return;

        amp      = longint'(reg_equil);
        abs_err  = (err < 0) ? -err : err;
        abs_rate = (rate < 0) ? -rate : rate;
        if (abs_err > longint'(reg_err_thr) &&
            (abs_rate < longint'(reg_rate_thr) || ((err < 0) == (rate < 0)))) begin
            // Q16.16 product back to Q8.8, round half up
            amp += (longint'(reg_gain) * err + 128) >>> 8;
            fix.boost = 1'b1;
        end
        fix.amplitude  = 16'(sat16(amp));
        fix.error_rate = 16'(rate);
        last_fix_us    = t_now;
    endfunction

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 200)
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (no_gaps)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 29);
    end

    always @(posedge i_clk) begin
        t_correction want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_corrections.size() == 0) begin
                mismatch_count++;
                $display("%0t: correction %h arrived with none expected, expected none",
                         $time, m_axis_tdata);
            end else begin
                want = expected_corrections.pop_front();
                corrections_checked++;
                if (want.boost)
                    boosts_seen++;
                check_field("amplitude", want.amplitude, m_axis_tdata[15:0]);
                check_field("boost_applied", 16'(want.boost), 16'(m_axis_tdata[16]));
                check_field("error_rate", want.error_rate, m_axis_tdata[32:17]);
                check_field("padding", 16'd0, 16'(m_axis_tdata[39:33]));
            end
        end
    end

    task automatic send_sample(input logic signed [15:0] desired,
                               input logic signed [15:0] measured,
                               input logic [47:0] t_sample, input logic [47:0] t_now);
        t_correction fix;
        bit          issued;
        while (!no_gaps && $urandom_range(99) < 29) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= {t_now, t_sample, measured, desired};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        items_sent++;
        predict_correction(desired, measured, t_sample, t_now, issued, fix);
        if (issued)
            expected_corrections.insert(expected_corrections.size(), fix);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [23:0] value);
        i_cfg_index <= index;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        reg_writes++;
        case (index)
            REG_GAIN:     reg_gain     = value[15:0];
            REG_MAX_AGE:  reg_max_age  = value;
            REG_PATIENCE: reg_patience = value;
            REG_RATE_THR: reg_rate_thr = value[14:0];
            REG_ERR_THR:  reg_err_thr  = value[14:0];
            REG_EQUIL:    reg_equil    = value[15:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic pause_stream_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_corrections.size() != 0)
            @(posedge i_clk);
    endtask

    // a sample that yields no correction may still be in the divider
    task automatic settle_block();
        pause_stream_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic drive_speed_track(input int count, input int unsigned step_hi);
        logic signed [15:0] desired, measured;
        logic [47:0]        t_sample, t_now, prev_stamp;
        int unsigned        kind, spread;
        prev_stamp = track_now_us;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2)
                pause_stream_until_drained();
            track_now_us += 48'($urandom_range(step_hi));
            t_now    = track_now_us;
            spread   = ($urandom_range(9) == 0) ? 20000 : 2000;
            desired  = 16'($urandom_range(8000));
            measured = 16'(int'(desired) - int'($urandom_range(2 * spread)) + int'(spread));
            t_sample = track_now_us - 48'($urandom_range(2000));
            kind     = $urandom_range(99);
            if (kind >= 72 && kind < 82) begin
                // repeated, future or zero stamp
                case ($urandom_range(2))
                    0:       t_sample = prev_stamp;
                    1:       t_sample = track_now_us + 48'($urandom_range(3 * step_hi + 1));
                    default: t_sample = '0;
                endcase
            end else if (kind >= 82 && kind < 92) begin
                desired  = 16'($urandom);
                measured = 16'($urandom);
                t_sample = {16'($urandom), $urandom};
            end else if (kind >= 92) begin
                t_now = track_now_us - 48'($urandom_range(4 * step_hi));
            end
            send_sample(desired, measured, t_sample, t_now);
            prev_stamp = t_sample;
        end
    endtask

    task automatic test_reset_defaults();
        // first correction lands exactly on the patience boundary
        send_sample(16'sd3000, 16'sd0, 48'd4000000, 48'd4000000);
        send_sample(16'sd1000, 16'sd1200, 48'd4500000, 48'd7999999);
        send_sample(-16'sd500, 16'sd2000, 48'd8000000, 48'd8000000);
        // oldest entry reaches the age limit exactly
        send_sample(16'sd0, 16'sd0, 48'd8100000, 48'd8100000);
        send_sample(16'sd200, 16'sd0, 48'd8200000, 48'd12100000);
        track_now_us = 48'd12100000;
    endtask

    task automatic test_field_extremes();
        logic [47:0] t;
        settle_block();
        t = track_now_us;
        write_register(REG_PATIENCE, 24'd0);
        write_register(REG_MAX_AGE, 24'hFFFFFF);
        write_register(REG_GAIN, 24'h00FFFF);
        write_register(REG_RATE_THR, 24'd0);
        write_register(REG_ERR_THR, 24'd0);
        write_register(REG_EQUIL, 24'h007FFF);
        send_sample(16'sd32767, -16'sd32768, t + 1000, t + 1000);
        send_sample(-16'sd32768, 16'sd32767, t + 2000, t + 2000);
        send_sample(16'sd0, 16'sd0, t + 3000, t + 3000);
        send_sample(16'sd1000, -16'sd1000, t + 900000, t + 4000);
        // stamps at or before the oldest kept sample saturate the rate
        send_sample(-16'sd6000, 16'sd0, 48'd0, t + 5000);
        send_sample(16'sd6000, 16'sd0, 48'd0, t + 6000);
        send_sample(16'sd100, 16'sd300, t + 7000, t + 7000);

        settle_block();
        write_register(REG_GAIN, 24'd0);
        write_register(REG_EQUIL, 24'h008000);
        write_register(REG_ERR_THR, 24'hFFFFFF);
        write_register(REG_RATE_THR, 24'hFFFFFF);
        send_sample(-16'sd32768, 16'sd0, t + 8000, t + 8000);
        send_sample(16'sd32767, 16'sd0, t + 9000, t + 9000);
        send_sample(16'sd0, 16'sd32767, t + 10000, t + 10000);
        track_now_us = t + 10000;
    endtask

    task automatic test_random_settings(input int phases, input int per_phase);
        int unsigned step_hi;
        logic [23:0] gain_w, age_w, pat_w, rthr_w, ethr_w, equil_w;
        for (int p = 0; p < phases; p++) begin
            settle_block();
            step_hi = $urandom_range(400000, 5000);
            gain_w  = 24'($urandom);
            age_w   = 24'($urandom_range(30 * step_hi, step_hi));
            pat_w   = 24'($urandom_range(2 * step_hi));
            rthr_w  = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(3000));
            ethr_w  = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(3000));
            equil_w = 24'($urandom);
            if (p == 0) begin
                gain_w = 24'hFFFFFF; age_w = 24'hFFFFFF; pat_w = 24'd0;
                rthr_w = 24'h007FFF; ethr_w = 24'd0; equil_w = 24'h007FFF;
            end else if (p == 1) begin
                gain_w = 24'd0; age_w = 24'd0; pat_w = 24'd0;
                rthr_w = 24'd0; ethr_w = 24'h007FFF; equil_w = 24'h008000;
            end else if (p == 2) begin
                // longest patience, so slow time steps to keep corrections coming
                step_hi = 3000000;
                age_w   = 24'hFFFFFF;
                pat_w   = 24'hFFFFFF;
            end
            write_register(REG_GAIN, gain_w);
            write_register(REG_MAX_AGE, age_w);
            write_register(REG_PATIENCE, pat_w);
            write_register(REG_RATE_THR, rthr_w);
            write_register(REG_ERR_THR, ethr_w);
            write_register(REG_EQUIL, equil_w);
            write_register(REG_SPARE_LO, 24'($urandom));
            write_register(REG_SPARE_HI, 24'($urandom));
            track_now_us += {8'd0, 8'($urandom), 32'($urandom)};
            drive_speed_track(per_phase, step_hi);
        end
    endtask

    task automatic test_back_to_back(input int count);
        settle_block();
        no_gaps = 1'b1;
        write_register(REG_PATIENCE, 24'd0);
        write_register(REG_MAX_AGE, 24'($urandom_range(2000000, 100000)));
        drive_speed_track(count, 50000);
        settle_block();
        no_gaps = 1'b0;
    endtask

    task automatic test_time_ceiling();
        settle_block();
        write_register(REG_PATIENCE, 24'd0);
        write_register(REG_MAX_AGE, 24'hFFFFFF);
        track_now_us = 48'hFFFF_FFF0_0000;
        for (int n = 0; n < 4; n++) begin
            track_now_us += 48'h3_0000 + 48'($urandom_range(65535));
            send_sample(16'($urandom), 16'($urandom), track_now_us - 100, track_now_us);
        end
        send_sample(16'sd500, -16'sd500, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_sample(-16'sd500, 16'sd500, 48'd0, 48'hFFFF_FFFF_FFFF);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_field_extremes();
        test_random_settings(9, 185);
        test_back_to_back(150);
        test_time_ceiling();
        pause_stream_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d speed samples through %0d register writes;", items_sent, reg_writes);
        $display("checked %0d corrections, %0d of them boosted, %0d mismatches.",
                 corrections_checked, boosts_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
hdl/serc_pkg.sv
hdl/speed_error_rate_corrector_top.sv
tb/speed_error_rate_corrector_top_test.sv
